// ----- rtl/core/rvaf_pkg.sv -----
// shared types and constants of the raft follower unit
package rvaf_pkg;

    localparam int LOG_DEPTH = 1024;
    localparam int LOG_AW    = $clog2(LOG_DEPTH);
    localparam int LEN_W     = $clog2(LOG_DEPTH + 1);
    localparam int TERM_W    = 31;
    localparam int ID_W      = 8;
    localparam int IDX_W     = 16;
    localparam int HANDLE_W  = 32;
    localparam int REQ_W     = 200;
    localparam int RES_W     = 40;

    localparam logic FUNC_VOTE   = 1'b0;
    localparam logic FUNC_APPEND = 1'b1;

    localparam logic [1:0] CMD_PUT = 2'd0;
    localparam logic [1:0] CMD_DEL = 2'd1;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } fsm_t;

    // last member sits in the lowest bits
    typedef struct packed {
        logic [HANDLE_W-1:0] value_handle;
        logic [HANDLE_W-1:0] key_handle;
        logic [1:0]          cmd_kind;
        logic                has_entry;
        logic [TERM_W-1:0]   prev_log_term;
        logic [IDX_W-1:0]    prev_log_index;
        logic [IDX_W-1:0]    last_log_index;
        logic [TERM_W-1:0]   last_log_term;
        logic [ID_W-1:0]     candidate_id;
        logic [TERM_W-1:0]   term;
    } req_t;

    typedef struct packed {
        logic [TERM_W-1:0] current_term;
        logic              vote_valid;
        logic [ID_W-1:0]   vote_id;
        logic [LEN_W-1:0]  log_length;
    } core_t;

    typedef struct packed {
        logic [RES_W-37:0] pad;
        logic              log_full;
        logic              save_request;
        logic              became_follower;
        logic              timer_reset;
        logic              ok;
        logic [TERM_W-1:0] reply_term;
    } res_t;

    typedef struct packed {
        logic              en;
        logic [LOG_AW-1:0] addr;
        logic [TERM_W-1:0] data;
    } wr_t;

endpackage

// ----- rtl/core/rvaf_log_ram.sv -----
// single-port-write, registered-read memory for the entry terms
module rvaf_log_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 31,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/rvaf_engine.sv -----
// vote and append decision logic, next state and log write-back
module rvaf_engine
    import rvaf_pkg::*;
(
    input  logic              func,
    input  req_t              req,
    input  core_t             core,
    input  logic [TERM_W-1:0] rd_term,
    output core_t             core_next,
    output res_t              res,
    output wr_t               wr
);

    logic [TERM_W-1:0] my_term;
    logic [LEN_W-1:0]  my_index;
    logic              forced;
    logic              grant;
    logic              mismatch;
    logic [IDX_W:0]    slot;

    always_comb begin
        core_next = core;
        res       = '0;
        wr        = '0;
        forced    = 1'b0;
        grant     = 1'b0;
        mismatch  = 1'b0;
        my_term   = '0;
        my_index  = '0;
        slot      = {1'b0, req.prev_log_index} + {{IDX_W{1'b0}}, 1'b1};

        if (func == FUNC_VOTE) begin
            if (req.term > core.current_term) begin
                forced                 = 1'b1;
                core_next.current_term = req.term;
                core_next.vote_valid   = 1'b0;
            end
            // entry zero only ever holds term zero
            if (core.log_length > LEN_W'(1)) begin
                my_term = rd_term;
            end
            if (core.log_length != '0) begin
                my_index = core.log_length - LEN_W'(1);
            end
            if ((!core_next.vote_valid || core.vote_id == req.candidate_id) &&
                req.term >= core_next.current_term &&
                (my_term < req.last_log_term ||
                 (my_term == req.last_log_term &&
                  {{(IDX_W + 1 - LEN_W){1'b0}}, my_index} <=
                  {1'b0, req.last_log_index}))) begin
                grant                = 1'b1;
                core_next.vote_valid = 1'b1;
                core_next.vote_id    = req.candidate_id;
            end
            res.reply_term      = core_next.current_term;
            res.ok              = grant;
            res.became_follower = forced;
            res.save_request    = 1'b1;
        end else begin
            res.reply_term = core.current_term;
            if (req.term >= core.current_term) begin
                res.timer_reset     = 1'b1;
                res.became_follower = 1'b1;
                if (req.term > core.current_term) begin
                    core_next.vote_valid = 1'b0;
                    res.save_request     = 1'b1;
                end
                core_next.current_term = req.term;
                if (!req.has_entry) begin
                    res.ok = 1'b1;
                end else begin
                    if (req.prev_log_index != '0) begin
                        mismatch = ({1'b0, req.prev_log_index} >=
                                    {{(IDX_W + 1 - LEN_W){1'b0}}, core.log_length}) ||
                                   (rd_term != req.prev_log_term);
                    end
                    if (!mismatch) begin
                        // prev index is zero or below the log length here, so the slot fits
                        if ({{(IDX_W + 1 - LEN_W){1'b0}}, core.log_length} != slot) begin
                            core_next.log_length = slot[LEN_W-1:0];
                            res.save_request     = 1'b1;
                        end
                        if (req.cmd_kind == CMD_PUT || req.cmd_kind == CMD_DEL) begin
                            if (slot >= (IDX_W + 1)'(LOG_DEPTH)) begin
                                res.log_full = 1'b1;
                            end else begin
                                wr.en                = 1'b1;
                                wr.addr              = slot[LOG_AW-1:0];
                                wr.data              = req.term;
                                core_next.log_length = slot[LEN_W-1:0] + LEN_W'(1);
                                res.ok               = 1'b1;
                                res.save_request     = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

endmodule

// ----- rtl/core/raft_vote_and_append_follower_unit.sv -----
// top level of the raft follower unit: request capture, log memory and reply register
//
// one request stream in, one reply stream out; every request gives exactly one reply
// s_tuser carries the request kind (vote or append entries), s_tdata the request fields
// a request is taken only while the unit is idle; the log memory is read at the
// edge that takes it, at the previous index for an append or at the last entry
// for a vote; the decision and log write-back follow once the reply register is free
// m_tvalid is registered and rises as the reply register is loaded; a new request
// is taken only after the last one has been decided
// the reply register holds one result: while it waits for m_tready the next request
// is still taken and read, and its decision waits until the register is free
// reset (aresetn low, synchronous) clears the term to zero, drops the vote,
// empties the log and drops m_tvalid; the log memory needs no clearing pass
// since entries beyond the log length are never consulted
module raft_vote_and_append_follower_unit
    import rvaf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // term, candidate_id, last_log_term, last_log_index, prev_log_index,
    // prev_log_term, has_entry, cmd_kind, key_handle, value_handle
    input  logic [REQ_W-1:0] s_tdata,
    // func
    input  logic             s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // reply_term, ok, timer_reset, became_follower, save_request, log_full, zero pad
    output logic [RES_W-1:0] m_tdata
);

    fsm_t              fsm_reg, fsm_next;
    req_t              req_reg;
    logic              func_reg;
    core_t             core_reg, core_next;
    logic              m_tvalid_reg, m_tvalid_next;
    res_t              res_reg;
    res_t              res;
    wr_t               wr;
    req_t              s_req;
    logic              accept;
    logic              fire;
    logic [LEN_W-1:0]  last_len;
    logic [LOG_AW-1:0] rd_addr;
    logic [TERM_W-1:0] rd_term;

    assign s_req    = req_t'(s_tdata);
    assign accept   = s_tvalid && s_tready;
    assign last_len = core_reg.log_length - LEN_W'(1);
    assign rd_addr  = (s_tuser == FUNC_APPEND) ? s_req.prev_log_index[LOG_AW-1:0]
                                               : last_len[LOG_AW-1:0];

    rvaf_log_ram #(
        .DEPTH (LOG_DEPTH),
        .WIDTH (TERM_W)
    ) u_log_ram (
        .aclk  (aclk),
        .we    (wr.en && fire),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (rd_term)
    );

    rvaf_engine u_engine (
        .func      (func_reg),
        .req       (req_reg),
        .core      (core_reg),
        .rd_term   (rd_term),
        .core_next (core_next),
        .res       (res),
        .wr        (wr)
    );

    always_comb begin
        fsm_next      = fsm_reg;
        s_tready      = 1'b0;
        fire          = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (fsm_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    fsm_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!m_tvalid_reg || m_tready) begin
                    fire          = 1'b1;
                    m_tvalid_next = 1'b1;
                    fsm_next      = ST_IDLE;
                end
            end
            default: begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg      <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            core_reg     <= '0;
        end else begin
            fsm_reg      <= fsm_next;
            m_tvalid_reg <= m_tvalid_next;
            if (fire) begin
                core_reg <= core_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg  <= s_req;
            func_reg <= s_tuser;
        end
        if (fire) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = res_reg;

endmodule

// ----- tb/testbench.sv -----
// testbench for the raft follower unit: directed table, random request traffic, reply predictor
module testbench
    import rvaf_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [TERM_W-1:0] TERM_MAX = '1;
    localparam logic [TERM_W-1:0] TERM_HIGH = 31'h7FFF_0000;
    localparam logic [1:0] CMD_UNKNOWN = 2'd2;
    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int RANDOM_REQUESTS = 1800;
    localparam int REQUEST_CAP = 2400;
    localparam int WATCHDOG_CYCLES = 2000;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE
    } rx_mode_t;

    typedef struct {
        logic fn;
        req_t rq;
        logic known;
        res_t want;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [REQ_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [RES_W-1:0] m_tdata;

    // follower state as predicted
    logic [TERM_W-1:0] fol_term;
    logic fol_voted;
    logic [ID_W-1:0] fol_vote_id;
    int fol_len;
    logic [TERM_W-1:0] log_term [LOG_DEPTH];

    res_t replies_due [$];
    dir_row_t head_rows [$];
    dir_row_t tail_rows [$];
    int reply_errors = 0;
    int burst_left = 0;
    int full_seen = 0;
    int quiet = 0;
    int rx_left = 0;
    rx_mode_t rx_mode = RX_OPEN;

    raft_vote_and_append_follower_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic res_t predict_reply(input logic fn, input req_t rq);
        res_t r;
        logic [TERM_W-1:0] own_term;
        int own_idx;
        int prev;
        r = '0;
        prev = rq.prev_log_index;
        if (fn == FUNC_VOTE) begin
            if (rq.term > fol_term) begin
                fol_term = rq.term;
                fol_voted = 1'b0;
                r.became_follower = 1'b1;
            end
            own_term = '0;
            own_idx = 0;
            if (fol_len > 0) begin
                own_term = log_term[fol_len-1];
                own_idx = fol_len - 1;
            end
            if ((!fol_voted || fol_vote_id == rq.candidate_id) && rq.term >= fol_term &&
                (own_term < rq.last_log_term ||
                 (own_term == rq.last_log_term && own_idx <= int'(rq.last_log_index)))) begin
                r.ok = 1'b1;
                fol_voted = 1'b1;
                fol_vote_id = rq.candidate_id;
            end
            r.reply_term = fol_term;
            r.save_request = 1'b1;
            return r;
        end
        r.reply_term = fol_term;
        if (rq.term < fol_term)
            return r;
        if (rq.term > fol_term) begin
            fol_voted = 1'b0;
            r.save_request = 1'b1;
        end
        fol_term = rq.term;
        r.timer_reset = 1'b1;
        r.became_follower = 1'b1;
        if (!rq.has_entry) begin
            r.ok = 1'b1;
            return r;
        end
        if (prev > 0) begin
            if (prev >= fol_len)
                return r;
            if (log_term[prev] != rq.prev_log_term)
                return r;
        end
        // cut the log back so that it ends at the previous index
        if (fol_len == 0) begin
            log_term[0] = '0;
            fol_len = 1;
            r.save_request = 1'b1;
        end else if (fol_len != prev + 1) begin
            fol_len = prev + 1;
            r.save_request = 1'b1;
        end
        if (rq.cmd_kind != CMD_PUT && rq.cmd_kind != CMD_DEL)
            return r;
        if (prev + 1 >= LOG_DEPTH) begin
            r.log_full = 1'b1;
            return r;
        end
        log_term[prev+1] = rq.term;
        fol_len = prev + 2;
        r.ok = 1'b1;
        r.save_request = 1'b1;
        return r;
    endfunction

    function automatic res_t rply(input logic [TERM_W-1:0] rt, input logic ok, input logic tr,
                                  input logic bf, input logic sv, input logic lf);
        res_t r;
        r = '0;
        r.reply_term = rt;
        r.ok = ok;
        r.timer_reset = tr;
        r.became_follower = bf;
        r.save_request = sv;
        r.log_full = lf;
        return r;
    endfunction

    function automatic dir_row_t mk_row(input logic fn, input logic [TERM_W-1:0] trm,
                                        input logic [ID_W-1:0] cand,
                                        input logic [TERM_W-1:0] llt,
                                        input logic [IDX_W-1:0] lli,
                                        input logic [IDX_W-1:0] prv,
                                        input logic [TERM_W-1:0] ptrm, input logic he,
                                        input logic [1:0] kind, input logic [31:0] key,
                                        input logic [31:0] val, input logic known,
                                        input res_t want);
        dir_row_t d;
        d.fn = fn;
        d.rq.term = trm;
        d.rq.candidate_id = cand;
        d.rq.last_log_term = llt;
        d.rq.last_log_index = lli;
        d.rq.prev_log_index = prv;
        d.rq.prev_log_term = ptrm;
        d.rq.has_entry = he;
        d.rq.cmd_kind = kind;
        d.rq.key_handle = key;
        d.rq.value_handle = val;
        d.known = known;
        d.want = want;
        return d;
    endfunction

    function automatic void add_head(input dir_row_t d);
        head_rows.insert(head_rows.size(), d);
    endfunction

    function automatic void add_tail(input dir_row_t d);
        tail_rows.insert(tail_rows.size(), d);
    endfunction

    task automatic send_request(input logic fn, input req_t rq, input logic known,
                                input res_t want);
        res_t calc;
        if (burst_left == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 6);
        end
        burst_left = burst_left - 1;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= rq;
        do @(posedge aclk); while (!s_tready);
        calc = predict_reply(fn, rq);
        if (calc.log_full)
            full_seen = full_seen + 1;
        replies_due.insert(replies_due.size(), known ? want : calc);
    endtask

    task automatic random_request(output logic fn, output req_t rq);
        int pick;
        int prev;
        logic [TERM_W-1:0] lt;
        int li;
        fn = FUNC_APPEND;
        rq.term = fol_term;
        rq.candidate_id = $urandom;
        rq.last_log_term = $urandom;
        rq.last_log_index = $urandom;
        rq.prev_log_index = $urandom;
        rq.prev_log_term = $urandom;
        rq.has_entry = 1'b1;
        rq.cmd_kind = ($urandom_range(0, 19) == 0)
                      ? ($urandom_range(0, 1) ? CMD_UNKNOWN : CMD_RESERVED)
                      : ($urandom_range(0, 1) ? CMD_DEL : CMD_PUT);
        rq.key_handle = $urandom;
        rq.value_handle = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            // grow at the tail; once full, half the time cut back one to three entries first
            prev = (fol_len == 0) ? 0 : fol_len - 1;
            if (fol_len == LOG_DEPTH && $urandom_range(0, 1))
                prev = prev - $urandom_range(1, 3);
            rq.prev_log_index = prev;
            if (fol_len > 0)
                rq.prev_log_term = log_term[prev];
            if ($urandom_range(0, 19) == 0)
                rq.term = fol_term + $urandom_range(1, 2);
        end else if (pick < 76) begin
            if (fol_len > 0) begin
                prev = fol_len - $urandom_range(1, (fol_len < 3) ? fol_len : 3);
                rq.prev_log_index = prev;
                rq.prev_log_term = log_term[prev];
            end
        end else if (pick < 80) begin
            if (fol_len > 1 && $urandom_range(0, 1)) begin
                prev = $urandom_range(1, fol_len - 1);
                rq.prev_log_index = prev;
                rq.prev_log_term = log_term[prev] + 1'b1;
            end else begin
                rq.prev_log_index = $urandom_range((fol_len > 0) ? fol_len : 1, 65535);
            end
        end else if (pick < 84) begin
            rq.has_entry = 1'b0;
            if ($urandom_range(0, 4) == 0)
                rq.term = fol_term + 1'b1;
        end else if (pick < 88) begin
            fn = $urandom_range(0, 1);
            rq.term = (fol_term == 0) ? '0 : $urandom_range(0, fol_term - 1);
        end else if (pick < 98) begin
            fn = FUNC_VOTE;
            if ($urandom_range(0, 4) == 0)
                rq.term = fol_term + 1'b1;
            if ($urandom_range(0, 9) < 7)
                rq.candidate_id = $urandom_range(0, 3);
            if ($urandom_range(0, 1)) begin
                lt = (fol_len > 0) ? log_term[fol_len-1] : '0;
                li = (fol_len > 0) ? fol_len - 1 : 0;
                rq.last_log_term = lt + $urandom_range(0, 2) - 1;
                rq.last_log_index = li + $urandom_range(0, 2) - 1;
            end
        end else begin
            fn = $urandom_range(0, 1);
            rq.term = $urandom_range(0, fol_term);
        end
    endtask

    // receiver stalls
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_left = $urandom_range(40, 300);
        end
        rx_left = rx_left - 1;
        case (rx_mode)
            RX_OPEN: m_tready <= 1'b1;
            RX_COIN: m_tready <= $urandom_range(0, 1);
            default: m_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        got = res_t'(m_tdata);
        if (aresetn && m_tvalid && m_tready) begin
            if (replies_due.size() == 0) begin
                reply_errors = reply_errors + 1;
                if (reply_errors <= 10)
                    $display("unexpected reply: term %0d ok %b", got.reply_term, got.ok);
            end else begin
                want = replies_due.pop_front();
                if (got.reply_term !== want.reply_term || got.ok !== want.ok ||
                    got.timer_reset !== want.timer_reset ||
                    got.became_follower !== want.became_follower ||
                    got.save_request !== want.save_request ||
                    got.log_full !== want.log_full) begin
                    reply_errors = reply_errors + 1;
                    if (reply_errors <= 10)
                        $display("reply mismatch: expected term %0d ok %b tr %b bf %b sv %b lf %b,",
                                 want.reply_term, want.ok, want.timer_reset,
                                 want.became_follower, want.save_request, want.log_full,
                                 " got term %0d ok %b tr %b bf %b sv %b lf %b",
                                 got.reply_term, got.ok, got.timer_reset,
                                 got.became_follower, got.save_request, got.log_full);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet = 0;
        end else begin
            quiet = quiet + 1;
            if (quiet == WATCHDOG_CYCLES) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic fn;
        req_t rq;
        int sent;
        fol_term = '0;
        fol_voted = 1'b0;
        fol_vote_id = '0;
        fol_len = 0;

        add_head(mk_row(FUNC_VOTE, 0, 5, 0, 0, 0, 0, 0, CMD_PUT, 0, 0,
                        1, rply(0, 1, 0, 0, 1, 0)));
        add_head(mk_row(FUNC_VOTE, 0, 6, 0, 0, 0, 0, 0, CMD_PUT, 0, 0,
                        1, rply(0, 0, 0, 0, 1, 0)));
        add_head(mk_row(FUNC_APPEND, 0, 0, 0, 0, 0, 0, 0, CMD_PUT, 0, 0,
                        1, rply(0, 1, 1, 1, 0, 0)));
        // empty log with previous index zero creates the zero entry first
        add_head(mk_row(FUNC_APPEND, 3, 0, 0, 0, 0, 0, 1, CMD_PUT, '1, '1,
                        0, '0));
        add_head(mk_row(FUNC_APPEND, 3, 0, 0, 0, 1, 3, 1, CMD_DEL, 0, '1,
                        0, '0));
        add_head(mk_row(FUNC_APPEND, 3, 0, 0, 0, 5, 3, 1, CMD_PUT, 1, 2,
                        0, '0));
        add_head(mk_row(FUNC_APPEND, 3, 0, 0, 0, 2, 7, 1, CMD_PUT, 1, 2,
                        0, '0));
        add_head(mk_row(FUNC_APPEND, 3, 0, 0, 0, 1, 3, 1, CMD_UNKNOWN, 1, 2,
                        0, '0));
        add_head(mk_row(FUNC_APPEND, 3, 0, 0, 0, 1, 3, 1, CMD_RESERVED, 1, 2,
                        0, '0));
        add_head(mk_row(FUNC_APPEND, 3, 0, 0, 0, 0, 0, 1, CMD_PUT, 4, 5,
                        0, '0));
        add_head(mk_row(FUNC_APPEND, 2, 0, 0, 0, 0, 0, 1, CMD_PUT, 4, 5,
                        1, rply(3, 0, 0, 0, 0, 0)));
        add_head(mk_row(FUNC_VOTE, 3, 9, 3, 0, 0, 0, 0, CMD_PUT, 0, 0, 0, '0));
        add_head(mk_row(FUNC_VOTE, 3, 9, 2, 100, 0, 0, 0, CMD_PUT, 0, 0, 0, '0));
        add_head(mk_row(FUNC_VOTE, 3, 9, 3, 1, 0, 0, 0, CMD_PUT, 0, 0, 0, '0));
        add_head(mk_row(FUNC_VOTE, 4, 7, 3, 1, 0, 0, 0, CMD_PUT, 0, 0, 0, '0));
        add_head(mk_row(FUNC_VOTE, 4, 9, 9, 9, 0, 0, 0, CMD_PUT, 0, 0, 0, '0));
        add_head(mk_row(FUNC_VOTE, 4, 7, 9, 9, 0, 0, 0, CMD_PUT, 0, 0, 0, '0));
        add_head(mk_row(FUNC_APPEND, 4, 0, 0, 0, '1, TERM_MAX, 0, CMD_RESERVED,
                        '1, '1, 0, '0));
        add_head(mk_row(FUNC_APPEND, 4, 0, 0, 0, '1, TERM_MAX, 1, CMD_PUT,
                        '1, '1, 0, '0));
        add_head(mk_row(FUNC_VOTE, 2, '1, TERM_MAX, '1, 0, 0, 0, CMD_PUT, 0, 0,
                        1, rply(4, 0, 0, 0, 1, 0)));
        add_head(mk_row(FUNC_APPEND, TERM_HIGH, 0, 0, 0, '1, TERM_MAX, 0,
                        CMD_PUT, 0, 0, 0, '0));

        add_tail(mk_row(FUNC_VOTE, TERM_MAX, '1, TERM_MAX, '1, 0, 0, 0, CMD_PUT,
                        0, 0, 0, '0));
        add_tail(mk_row(FUNC_APPEND, TERM_MAX, 0, 0, 0, 0, 0, 0, CMD_PUT, 0, 0,
                        0, '0));
        add_tail(mk_row(FUNC_APPEND, 0, 0, 0, 0, 0, 0, 1, CMD_PUT, 0, 0,
                        1, rply(TERM_MAX, 0, 0, 0, 0, 0)));

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (head_rows[i])
            send_request(head_rows[i].fn, head_rows[i].rq, head_rows[i].known,
                         head_rows[i].want);

        // keep going past the nominal count until eight log-full replies have been predicted or the cap is hit
        sent = 0;
        while (sent < RANDOM_REQUESTS || (full_seen < 8 && sent < REQUEST_CAP)) begin
            random_request(fn, rq);
            send_request(fn, rq, 1'b0, '0);
            sent = sent + 1;
        end

        foreach (tail_rows[i])
            send_request(tail_rows[i].fn, tail_rows[i].rq, tail_rows[i].known,
                         tail_rows[i].want);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (reply_errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
